### design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master byte engine
// Phase codes, command codes, engine state and per-word result layout.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Default width of the half-bit delay counter
  localparam int DELAY_BITS_DEF = 16;
  // Delay register value after reset
  localparam int BIT_DELAY_RST  = 10;
  // Width of the delay register write data
  localparam int CFG_W          = 16;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;

  // Bus sequencer phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE = 15'b000_0000_0000_0001,
    PH_ST1  = 15'b000_0000_0000_0010,
    PH_WB1  = 15'b000_0000_0000_0100,
    PH_WB2  = 15'b000_0000_0000_1000,
    PH_WA1  = 15'b000_0000_0001_0000,
    PH_WA2  = 15'b000_0000_0010_0000,
    PH_WA3  = 15'b000_0000_0100_0000,
    PH_RB1  = 15'b000_0000_1000_0000,
    PH_RB2  = 15'b000_0001_0000_0000,
    PH_RA1  = 15'b000_0010_0000_0000,
    PH_RA2  = 15'b000_0100_0000_0000,
    PH_RA3  = 15'b000_1000_0000_0000,
    PH_SP1  = 15'b001_0000_0000_0000,
    PH_SP2  = 15'b010_0000_0000_0000,
    PH_SP3  = 15'b100_0000_0000_0000
  } phase_t;

  // Engine state apart from the wait counter
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bit_idx;
    logic [7:0]  shift;
    logic        scl_low;
    logic        sda_low;
    logic        ack;
    logic        nack;
    logic [7:0]  read_hold;
  } state_t;

  // One result word
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

### design/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if: valid/ready channels of the I2C master byte engine
// Command/tick channel, result channel and delay register write channel.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_byte;
  logic       read_flag;
  logic       last_byte;
  logic       sda_in;

  modport source (output valid, mode, data_byte, read_flag, last_byte, sda_in,
                  input ready);
  modport sink   (input valid, mode, data_byte, read_flag, last_byte, sda_in,
                  output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_ok;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                  ack_ok, read_data, rejected, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                  ack_ok, read_data, rejected, output ready);
endinterface

interface i2cm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [i2cm_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### design/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step: next-state logic of the I2C master byte engine
// Takes the current state and one input word, returns the state after the
// word and the result word. A zero delay finishes a command in closed form.
// ----------------------------------------------------------------------------
module i2cm_step #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
  input  i2cm_pkg::state_t        state_i,
  input  logic [DELAY_BITS-1:0]   wait_i,
  input  logic [DELAY_BITS-1:0]   delay_i,
  input  logic [2:0]              mode_i,
  input  logic [7:0]              data_i,
  input  logic                    rw_i,
  input  logic                    last_i,
  input  logic                    sda_i,
  output i2cm_pkg::state_t        state_o,
  output logic [DELAY_BITS-1:0]   wait_o,
  output i2cm_pkg::res_t          res_o
);

  // One phase action; a wait of zero lets the next phase run in the same word
  function automatic void run_phase(
    input  i2cm_pkg::state_t      si,
    input  logic [DELAY_BITS-1:0] dly,
    input  logic                  sda,
    output i2cm_pkg::state_t      so,
    output logic [DELAY_BITS-1:0] wo,
    output logic                  fo
  );
    so = si;
    wo = '0;
    fo = 1'b0;
    case (si.phase)
      i2cm_pkg::PH_ST1: begin
        so.scl_low = 1'b1;
        so.bit_idx = 3'd0;
        so.phase   = i2cm_pkg::PH_WB1;
      end
      i2cm_pkg::PH_WB1: begin
        so.sda_low = ~si.shift[7];
        so.scl_low = 1'b0;
        so.phase   = i2cm_pkg::PH_WB2;
        wo         = dly;
      end
      i2cm_pkg::PH_WB2: begin
        so.scl_low = 1'b1;
        so.shift   = {si.shift[6:0], 1'b0};
        if (si.bit_idx == 3'd7) begin
          so.phase = i2cm_pkg::PH_WA1;
        end else begin
          so.bit_idx = si.bit_idx + 3'd1;
          so.phase   = i2cm_pkg::PH_WB1;
        end
        wo = dly;
      end
      i2cm_pkg::PH_WA1: begin
        so.sda_low = 1'b0;
        so.scl_low = 1'b0;
        so.phase   = i2cm_pkg::PH_WA2;
        wo         = dly;
      end
      i2cm_pkg::PH_WA2: begin
        so.ack     = ~sda;
        so.scl_low = 1'b1;
        so.phase   = i2cm_pkg::PH_WA3;
        wo         = dly;
      end
      i2cm_pkg::PH_WA3: begin
        so.sda_low = 1'b1;
        so.phase   = i2cm_pkg::PH_IDLE;
        fo         = 1'b1;
      end
      i2cm_pkg::PH_RB1: begin
        so.scl_low = 1'b0;
        so.phase   = i2cm_pkg::PH_RB2;
        wo         = dly;
      end
      i2cm_pkg::PH_RB2: begin
        so.shift   = {si.shift[6:0], sda};
        so.scl_low = 1'b1;
        if (si.bit_idx == 3'd7) begin
          so.phase = i2cm_pkg::PH_RA1;
        end else begin
          so.bit_idx = si.bit_idx + 3'd1;
          so.phase   = i2cm_pkg::PH_RB1;
          wo         = dly;
        end
      end
      i2cm_pkg::PH_RA1: begin
        so.sda_low = ~si.nack;
        so.scl_low = 1'b0;
        so.phase   = i2cm_pkg::PH_RA2;
        wo         = dly;
      end
      i2cm_pkg::PH_RA2: begin
        so.scl_low = 1'b1;
        so.phase   = i2cm_pkg::PH_RA3;
        wo         = dly;
      end
      i2cm_pkg::PH_RA3: begin
        so.sda_low   = 1'b1;
        so.read_hold = si.shift;
        so.phase     = i2cm_pkg::PH_IDLE;
        fo           = 1'b1;
      end
      i2cm_pkg::PH_SP1: begin
        so.scl_low = 1'b0;
        so.phase   = i2cm_pkg::PH_SP2;
        wo         = dly;
      end
      i2cm_pkg::PH_SP2: begin
        so.sda_low = 1'b0;
        so.phase   = i2cm_pkg::PH_SP3;
        wo         = dly;
      end
      i2cm_pkg::PH_SP3: begin
        so.phase = i2cm_pkg::PH_IDLE;
        fo       = 1'b1;
      end
      default: begin
        so.phase = i2cm_pkg::PH_IDLE;
      end
    endcase
  endfunction

  i2cm_pkg::state_t      s0, s1, s2;
  logic [DELAY_BITS-1:0] w0, w1, w2;
  logic                  fin0, fin1, fin2;
  logic                  rej;
  logic                  busy;

  // Take the command or count down, then run at most two phase actions
  always_comb begin
    s0   = state_i;
    w0   = wait_i;
    fin0 = 1'b0;
    rej  = 1'b0;
    busy = (state_i.phase != i2cm_pkg::PH_IDLE);
    if (busy) begin
      rej = (mode_i inside {i2cm_pkg::MODE_START, i2cm_pkg::MODE_WRITE,
                            i2cm_pkg::MODE_READ, i2cm_pkg::MODE_STOP});
      if (wait_i != '0) begin
        w0 = wait_i - DELAY_BITS'(1);
      end
    end else if (delay_i == '0) begin
      // Zero delay: the whole command completes on this word
      case (mode_i)
        i2cm_pkg::MODE_START, i2cm_pkg::MODE_WRITE: begin
          s0.bit_idx = 3'd7;
          s0.shift   = 8'd0;
          s0.scl_low = 1'b1;
          s0.sda_low = 1'b1;
          s0.ack     = ~sda_i;
          fin0       = 1'b1;
        end
        i2cm_pkg::MODE_READ: begin
          s0.bit_idx   = 3'd7;
          s0.shift     = {8{sda_i}};
          s0.read_hold = {8{sda_i}};
          s0.nack      = last_i;
          s0.scl_low   = 1'b1;
          s0.sda_low   = 1'b1;
          fin0         = 1'b1;
        end
        i2cm_pkg::MODE_STOP: begin
          s0.scl_low = 1'b0;
          s0.sda_low = 1'b0;
          fin0       = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode_i)
        i2cm_pkg::MODE_START: begin
          s0.sda_low = 1'b1;
          s0.shift   = {data_i[6:0], rw_i};
          s0.phase   = i2cm_pkg::PH_ST1;
          w0         = delay_i;
        end
        i2cm_pkg::MODE_WRITE: begin
          s0.shift   = data_i;
          s0.bit_idx = 3'd0;
          s0.phase   = i2cm_pkg::PH_WB1;
          w0         = '0;
        end
        i2cm_pkg::MODE_READ: begin
          s0.sda_low = 1'b0;
          s0.shift   = 8'd0;
          s0.bit_idx = 3'd0;
          s0.nack    = last_i;
          s0.phase   = i2cm_pkg::PH_RB1;
          w0         = delay_i;
        end
        i2cm_pkg::MODE_STOP: begin
          s0.sda_low = 1'b1;
          s0.phase   = i2cm_pkg::PH_SP1;
          w0         = delay_i;
        end
        default: begin
        end
      endcase
    end

    // First phase action when the wait has run out
    s1   = s0;
    w1   = w0;
    fin1 = 1'b0;
    if (s0.phase != i2cm_pkg::PH_IDLE && w0 == '0) begin
      run_phase(s0, delay_i, sda_i, s1, w1, fin1);
    end

    // Second action follows a phase that does not wait
    s2   = s1;
    w2   = w1;
    fin2 = 1'b0;
    if (s1.phase != i2cm_pkg::PH_IDLE && w1 == '0) begin
      run_phase(s1, delay_i, sda_i, s2, w2, fin2);
    end
  end

  // Pack the result word
  assign state_o = s2;
  assign wait_o  = w2;
  always_comb begin
    res_o.scl_pull_low = s2.scl_low;
    res_o.sda_pull_low = s2.sda_low;
    res_o.busy_res     = (s2.phase != i2cm_pkg::PH_IDLE);
    res_o.done_res     = fin0 | fin1 | fin2;
    res_o.ack_ok       = s2.ack;
    res_o.read_data    = s2.read_hold;
    res_o.rejected     = rej;
  end

endmodule

### design/i2c_master_byte_engine.sv
// A result word is registered and offered in the cycle after its word is accepted.
// Throughput: one word per cycle while the sink takes each result word; the state update
//   keeps pace and the result register frees itself as the sink takes each word.
// Reset (rst_n low at a clock edge): sequencer idle, both lines released,
//   delay register back to 10, no result word pending.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: open-drain I2C master, one tick or command per word
// Sequences SCL and SDA for start plus address, byte write, byte read and
// stop; every half-bit wait lasts the programmed number of ticks.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  i2cm_in_if.sink      in_ch,
  i2cm_out_if.source   out_ch,
  i2cm_cfg_if.sink     cfg_ch
);

  logic [DELAY_BITS-1:0] delay_r;
  logic [DELAY_BITS-1:0] wait_r, wait_nxt;
  i2cm_pkg::state_t      state_r, state_nxt;
  i2cm_pkg::res_t        res_nxt, res_r;
  logic                  out_valid_r;
  logic                  in_fire;

  // Accept a word whenever the result register is free or being drained
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_BITS'(i2cm_pkg::BIT_DELAY_RST);
    end else if (cfg_ch.valid) begin
      delay_r <= DELAY_BITS'(cfg_ch.data);
    end
  end

  i2cm_step #(
    .DELAY_BITS (DELAY_BITS)
  ) u_step (
    .state_i (state_r),
    .wait_i  (wait_r),
    .delay_i (delay_r),
    .mode_i  (in_ch.mode),
    .data_i  (in_ch.data_byte),
    .rw_i    (in_ch.read_flag),
    .last_i  (in_ch.last_byte),
    .sda_i   (in_ch.sda_in),
    .state_o (state_nxt),
    .wait_o  (wait_nxt),
    .res_o   (res_nxt)
  );

  // Advance the sequencer on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: i2cm_pkg::PH_IDLE, bit_idx: 3'd0, shift: 8'd0,
                   scl_low: 1'b0, sda_low: 1'b0, ack: 1'b0, nack: 1'b0,
                   read_hold: 8'd0};
      wait_r  <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_pull_low = res_r.scl_pull_low;
  assign out_ch.sda_pull_low = res_r.sda_pull_low;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.ack_ok       = res_r.ack_ok;
  assign out_ch.read_data    = res_r.read_data;
  assign out_ch.rejected     = res_r.rejected;

`ifndef NO_ASSERTIONS
  // An idle sequencer has no wait pending
  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == i2cm_pkg::PH_IDLE |-> wait_r == '0)
    else $error("wait counter running while idle");

  // A pending wait never exceeds the programmed delay
  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != i2cm_pkg::PH_IDLE |-> wait_r <= delay_r)
    else $error("wait counter above bit delay");

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_nxt.done_res |=> state_r.phase == i2cm_pkg::PH_IDLE)
    else $error("sequencer busy after done");

  // Done and busy never show together
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.done_res && res_r.busy_res))
    else $error("result word both done and busy");
`endif

endmodule

### test/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker: result checker for the I2C master byte engine
// Watches the command, result and delay register channels, runs its own
// copy of the bus sequencer, stepped on every accepted word, and compares
// each result word, field by field, with the oldest predicted bus status.
// ----------------------------------------------------------------------------
module i2cm_checker #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  i2cm_in_if   in_mon,
  i2cm_out_if  out_mon,
  i2cm_cfg_if  cfg_mon,
  input  logic end_of_test,
  output int   fail_count
);

  // Shadow copy of the engine
  i2cm_pkg::state_t      eng;
  logic [DELAY_BITS-1:0] half_bit_delay;
  logic [DELAY_BITS-1:0] wait_left;
  logic                  cmd_done;

  // Predicted bus status words, oldest first
  i2cm_pkg::res_t bus_status_q[$];

  int err_total = 0;
  int word_no   = 0;
  bit end_seen  = 1'b0;

  assign fail_count = err_total;

  // Print one line per failure and count it
  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_total++;
  endtask

  task automatic match_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report($sformatf("result word %0d: %s is 0x%0h, expected 0x%0h",
                       word_no, name, got, want));
  endtask

  function automatic void reset_engine();
    eng.phase      = i2cm_pkg::PH_IDLE;
    eng.bit_idx    = '0;
    eng.shift      = '0;
    eng.scl_low    = 1'b0;
    eng.sda_low    = 1'b0;
    eng.ack        = 1'b0;
    eng.nack       = 1'b0;
    eng.read_hold  = '0;
    wait_left      = '0;
    cmd_done       = 1'b0;
    half_bit_delay = DELAY_BITS'(i2cm_pkg::BIT_DELAY_RST);
  endfunction

  // Enter a phase after a full half-bit wait
  function automatic void arm_wait(i2cm_pkg::phase_t nxt);
    eng.phase = nxt;
    wait_left = half_bit_delay;
  endfunction

  // Enter a phase that acts on the same word
  function automatic void jump_to(i2cm_pkg::phase_t nxt);
    eng.phase = nxt;
    wait_left = '0;
  endfunction

  function automatic void complete_cmd();
    eng.phase = i2cm_pkg::PH_IDLE;
    wait_left = '0;
    cmd_done  = 1'b1;
  endfunction

  // Carry out the action of the current phase once its wait has run out
  function automatic void phase_action(logic sda);
    case (eng.phase)
      i2cm_pkg::PH_ST1: begin
        eng.scl_low = 1'b1;
        eng.bit_idx = '0;
        jump_to(i2cm_pkg::PH_WB1);
      end
      i2cm_pkg::PH_WB1: begin
        eng.sda_low = ~eng.shift[7];
        eng.scl_low = 1'b0;
        arm_wait(i2cm_pkg::PH_WB2);
      end
      i2cm_pkg::PH_WB2: begin
        eng.scl_low = 1'b1;
        eng.shift   = {eng.shift[6:0], 1'b0};
        if (eng.bit_idx == 3'd7) begin
          arm_wait(i2cm_pkg::PH_WA1);
        end else begin
          eng.bit_idx = eng.bit_idx + 3'd1;
          arm_wait(i2cm_pkg::PH_WB1);
        end
      end
      i2cm_pkg::PH_WA1: begin
        eng.sda_low = 1'b0;
        eng.scl_low = 1'b0;
        arm_wait(i2cm_pkg::PH_WA2);
      end
      i2cm_pkg::PH_WA2: begin
        eng.ack     = ~sda;
        eng.scl_low = 1'b1;
        arm_wait(i2cm_pkg::PH_WA3);
      end
      i2cm_pkg::PH_WA3: begin
        eng.sda_low = 1'b1;
        complete_cmd();
      end
      i2cm_pkg::PH_RB1: begin
        eng.scl_low = 1'b0;
        arm_wait(i2cm_pkg::PH_RB2);
      end
      i2cm_pkg::PH_RB2: begin
        eng.shift   = {eng.shift[6:0], sda};
        eng.scl_low = 1'b1;
        if (eng.bit_idx == 3'd7) begin
          jump_to(i2cm_pkg::PH_RA1);
        end else begin
          eng.bit_idx = eng.bit_idx + 3'd1;
          arm_wait(i2cm_pkg::PH_RB1);
        end
      end
      i2cm_pkg::PH_RA1: begin
        eng.sda_low = ~eng.nack;
        eng.scl_low = 1'b0;
        arm_wait(i2cm_pkg::PH_RA2);
      end
      i2cm_pkg::PH_RA2: begin
        eng.scl_low = 1'b1;
        arm_wait(i2cm_pkg::PH_RA3);
      end
      i2cm_pkg::PH_RA3: begin
        eng.sda_low   = 1'b1;
        eng.read_hold = eng.shift;
        complete_cmd();
      end
      i2cm_pkg::PH_SP1: begin
        eng.scl_low = 1'b0;
        arm_wait(i2cm_pkg::PH_SP2);
      end
      i2cm_pkg::PH_SP2: begin
        eng.sda_low = 1'b0;
        arm_wait(i2cm_pkg::PH_SP3);
      end
      i2cm_pkg::PH_SP3: begin
        complete_cmd();
      end
      default: begin
        eng.phase = i2cm_pkg::PH_IDLE;
        wait_left = '0;
      end
    endcase
  endfunction

  // Advance the bus sequencer by one word and return the bus status after it
  function automatic i2cm_pkg::res_t bus_step(logic [2:0] mode, logic [7:0] data,
                                              logic rw, logic last, logic sda);
    i2cm_pkg::res_t st;
    logic           rej;
    int             guard;
    rej      = 1'b0;
    cmd_done = 1'b0;
    if (eng.phase != i2cm_pkg::PH_IDLE) begin
      // busy: drop commands, count down the wait
      if (mode >= i2cm_pkg::MODE_START && mode <= i2cm_pkg::MODE_STOP) rej = 1'b1;
      if (wait_left != '0) wait_left = wait_left - 1'b1;
    end else begin
      case (mode)
        i2cm_pkg::MODE_START: begin
          eng.sda_low = 1'b1;
          eng.shift   = {data[6:0], rw};
          arm_wait(i2cm_pkg::PH_ST1);
        end
        i2cm_pkg::MODE_WRITE: begin
          eng.shift   = data;
          eng.bit_idx = '0;
          jump_to(i2cm_pkg::PH_WB1);
        end
        i2cm_pkg::MODE_READ: begin
          eng.sda_low = 1'b0;
          eng.shift   = '0;
          eng.bit_idx = '0;
          eng.nack    = last;
          arm_wait(i2cm_pkg::PH_RB1);
        end
        i2cm_pkg::MODE_STOP: begin
          eng.sda_low = 1'b1;
          arm_wait(i2cm_pkg::PH_SP1);
        end
        default: ;
      endcase
    end
    // run every phase whose wait is already over
    for (guard = 0;
         guard < 64 && eng.phase != i2cm_pkg::PH_IDLE && wait_left == '0;
         guard++)
      phase_action(sda);
    st.scl_pull_low = eng.scl_low;
    st.sda_pull_low = eng.sda_low;
    st.busy_res     = (eng.phase != i2cm_pkg::PH_IDLE);
    st.done_res     = cmd_done;
    st.ack_ok       = eng.ack;
    st.read_data    = eng.read_hold;
    st.rejected     = rej;
    return st;
  endfunction

  always @(posedge clk) begin
    i2cm_pkg::res_t want;
    if (!rst_n) begin
      reset_engine();
      bus_status_q.delete();
    end else begin
      // compare the result word taken by the sink
      if (out_mon.valid && out_mon.ready) begin
        if (bus_status_q.size() == 0) begin
          report($sformatf("result word %0d arrived with nothing outstanding", word_no));
        end else begin
          want = bus_status_q.pop_front();
          match_field("scl_pull_low", out_mon.scl_pull_low, want.scl_pull_low);
          match_field("sda_pull_low", out_mon.sda_pull_low, want.sda_pull_low);
          match_field("busy_res",     out_mon.busy_res,     want.busy_res);
          match_field("done_res",     out_mon.done_res,     want.done_res);
          match_field("ack_ok",       out_mon.ack_ok,       want.ack_ok);
          match_field("read_data",    out_mon.read_data,    want.read_data);
          match_field("rejected",     out_mon.rejected,     want.rejected);
        end
        word_no++;
      end
      // update the delay register copy
      if (cfg_mon.valid && cfg_mon.ready)
        half_bit_delay = DELAY_BITS'(cfg_mon.data);
      // predict the status for the accepted command or tick
      if (in_mon.valid && in_mon.ready)
        bus_status_q.push_back(bus_step(in_mon.mode, in_mon.data_byte, in_mon.read_flag,
                                        in_mon.last_byte, in_mon.sda_in));
    end
    if (end_of_test && !end_seen) begin
      end_seen = 1'b1;
      if (bus_status_q.size() != 0)
        report($sformatf("%0d result words never arrived", bus_status_q.size()));
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the I2C master byte engine
// Drives directed commands at zero and small delays, random I2C transfers
// (start, bytes, stop) with injected busy commands and broken sequences over
// several half-bit delays, and one stop at a longer delay. Sender bursts,
// sink stalls, a no-progress watchdog and a cap on words sent; checking
// lives in i2cm_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEND_LIMIT     = 20000;
  localparam int PHASE_WORDS    = 30;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic end_of_test = 1'b0;
  int   fail_count;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_byte_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  i2cm_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .end_of_test (end_of_test),
    .fail_count  (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Progress counters, updated after the edge so stimulus reads settled values
  int   n_sent    = 0;
  int   n_recv    = 0;
  logic last_busy = 1'b0;
  int   stuck_cycles = 0;

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      n_recv    <= n_recv + 1;
      last_busy <= out_ch.busy_res;
    end
  end

  // Watchdog: end the run when nothing moves for too long or when too many
  // words have been sent, as when the engine never goes idle
  always @(posedge clk) begin
    if (n_sent >= SEND_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Sink stalls: rotate a pattern, pick a new one now and then
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age   = 0;
  bit          rx_full   = 1'b0;

  always @(negedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom) | 16'h1111;
        2:       stall_pat = 16'($urandom & $urandom) | 16'h0001;
        default: stall_pat = 16'($urandom) | 16'h0101;
      endcase
    end else begin
      pat_age--;
    end
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    out_ch.ready <= rx_full || stall_pat[0];
  end

  // Sender bursts
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  task automatic idle_cycle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Present one word and hold it until the engine takes it
  task automatic put_word(logic [2:0] m, logic [7:0] d, logic rw, logic lb, logic s);
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 8)) idle_cycle();
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= d;
    in_ch.read_flag <= rw;
    in_ch.last_byte <= lb;
    in_ch.sda_in    <= s;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic put_tick();
    put_word(i2cm_pkg::MODE_TICK, 8'($urandom), 1'($urandom), 1'($urandom),
             1'($urandom));
  endtask

  // Command with random content in every field
  task automatic put_cmd(logic [2:0] m);
    put_word(m, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Tick until a result after the command shows the engine idle again;
  // sprinkle in commands that should bounce off the busy engine, and unused codes
  task automatic finish_command(int cmd_cnt, int noise_pct);
    while (!(n_recv >= cmd_cnt && !last_busy)) begin
      if ($urandom_range(0, 99) < noise_pct)
        put_cmd(3'($urandom_range(1, 7)));
      else
        put_tick();
    end
  endtask

  task automatic issue(logic [2:0] m, int noise_pct);
    put_cmd(m);
    finish_command(n_sent, noise_pct);
  endtask

  // Hold off until every result is back and the engine sits idle
  task automatic settle();
    forever begin
      while (n_recv != n_sent) idle_cycle();
      if (!last_busy) break;
      put_tick();
    end
  endtask

  task automatic cfg_write(logic [15:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One bus transfer: mostly start, a few bytes, stop; now and then broken
  task automatic run_transfer(int noise_pct);
    if ($urandom_range(0, 9) != 0) issue(i2cm_pkg::MODE_START, noise_pct);
    repeat ($urandom_range(0, 3))
      issue(($urandom_range(0, 1) == 1) ? i2cm_pkg::MODE_WRITE : i2cm_pkg::MODE_READ,
            noise_pct);
    if ($urandom_range(0, 7) != 0) issue(i2cm_pkg::MODE_STOP, noise_pct);
    if ($urandom_range(0, 9) == 0) put_cmd(3'($urandom_range(5, 7)));
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) put_tick();
  endtask

  int phase_delays [8] = '{0, 1, 2, 3, 1, 0, 2, 1};

  initial begin
    int base;
    in_ch.valid     = 1'b0;
    in_ch.mode      = i2cm_pkg::MODE_TICK;
    in_ch.data_byte = '0;
    in_ch.read_flag = 1'b0;
    in_ch.last_byte = 1'b0;
    in_ch.sda_in    = 1'b1;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset delay: start plus address, with a write that must be refused
    put_word(i2cm_pkg::MODE_START, 8'h55, 1'b0, 1'b0, 1'b1);
    base = n_sent;
    put_word(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0);
    finish_command(base, 0);
    settle();

    // Zero delay: every command completes on its own word
    cfg_write(16'h0000);
    put_word(i2cm_pkg::MODE_START, 8'h7F, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_START, 8'h80, 1'b1, 1'b1, 1'b1);
    put_word(i2cm_pkg::MODE_START, 8'h00, 1'b1, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, 1'b1, 1'b1);
    put_word(i2cm_pkg::MODE_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_READ,  8'h00, 1'b0, 1'b0, 1'b1);
    put_word(i2cm_pkg::MODE_READ,  8'hFF, 1'b1, 1'b1, 1'b0);
    put_word(i2cm_pkg::MODE_READ,  8'h3C, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_STOP,  8'hFF, 1'b1, 1'b1, 1'b1);
    put_word(3'd5, 8'hFF, 1'b1, 1'b1, 1'b1);
    put_word(3'd6, 8'h00, 1'b0, 1'b0, 1'b0);
    put_word(3'd7, 8'h81, 1'b1, 1'b0, 1'b1);
    put_word(i2cm_pkg::MODE_TICK, 8'h7E, 1'b0, 1'b1, 1'b0);
    settle();

    // One tick per half bit: every command and an unused code while busy
    cfg_write(16'h0001);
    put_word(i2cm_pkg::MODE_START, 8'h3C, 1'b0, 1'b0, 1'b1);
    base = n_sent;
    put_word(i2cm_pkg::MODE_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_READ,  8'hC3, 1'b1, 1'b1, 1'b1);
    put_word(i2cm_pkg::MODE_STOP,  8'h00, 1'b0, 1'b0, 1'b0);
    put_word(i2cm_pkg::MODE_START, 8'hFF, 1'b1, 1'b1, 1'b1);
    put_word(3'd6, 8'h11, 1'b0, 1'b1, 1'b0);
    finish_command(base, 0);

    // Random transfers over a spread of half-bit delays
    foreach (phase_delays[i]) begin
      settle();
      cfg_write(16'(phase_delays[i]));
      base = n_sent;
      while (n_sent - base < PHASE_WORDS) begin
        run_transfer(8);
        if ($urandom_range(0, 29) == 0)
          while (n_recv != n_sent) idle_cycle();
      end
    end

    // Longer delay: a stop at full rate, refused commands while it runs
    settle();
    cfg_write(16'h0028);
    gaps_on = 1'b0;
    rx_full = 1'b1;
    put_cmd(i2cm_pkg::MODE_STOP);
    base = n_sent;
    put_cmd(i2cm_pkg::MODE_START);
    put_cmd(i2cm_pkg::MODE_WRITE);
    put_cmd(i2cm_pkg::MODE_READ);
    put_cmd(i2cm_pkg::MODE_STOP);
    put_cmd(3'd7);
    finish_command(base, 0);
    rx_full = 1'b0;
    gaps_on = 1'b1;

    // Drain and let the last result words reach the checker before the end check
    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
